// ===== rtl/bbis_pkg.sv =====
// Package with shared types and constants of the image scaler.
package bbis_pkg;
  localparam int unsigned MaxW = 256;
  localparam int unsigned MaxH = 256;
  localparam int unsigned AddrW = 16;
  localparam int unsigned CntW = 17;

  localparam logic [2:0] RegImgW = 3'd0;
  localparam logic [2:0] RegImgH = 3'd1;
  localparam logic [2:0] RegRx = 3'd2;
  localparam logic [2:0] RegRy = 3'd3;
  localparam logic [2:0] RegRw = 3'd4;
  localparam logic [2:0] RegRh = 3'd5;
  localparam logic [2:0] RegDw = 3'd6;
  localparam logic [2:0] RegDh = 3'd7;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StRegion = 2'd1;
  localparam logic [1:0] StNotReady = 2'd2;

  // Clamp a 9-bit size register to 1..256 (width and height share one maximum).
  function automatic logic [8:0] eff_size(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'(MaxW)) r = 9'(MaxW);
    return r;
  endfunction

  // Request to the pass unit for one 1-D scaling line.
  typedef struct packed {
    logic        go;
    logic        vert;
    logic [15:0] sb;
    logic [15:0] ss;
    logic [8:0]  n_src;
    logic [15:0] db;
    logic [15:0] ds;
    logic [8:0]  n_dst;
  } pass_req_t;
endpackage

// ===== rtl/bbis_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module bbis_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] q_q, q_d;
  logic [16:0] r_q, r_d;
  logic [15:0] den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [16:0] sh;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = '0;
    if (start_i) begin
      q_d = num_i; r_d = '0; den_d = den_i; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      sh = {r_q[15:0], q_q[31]};
      q_d = {q_q[30:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q};
        q_d[0] = 1'b1;
      end else begin
        r_d = sh;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = q_q;
endmodule

// ===== rtl/bbis_pass.sv =====
// Sequencer for one 1-D scaling line, driving the shared divider and the stores.
module bbis_pass (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbis_pkg::pass_req_t req_i,
  output logic                done_o,
  output logic                rd_en_o,
  output logic [15:0]         rd_addr_o,
  input  logic [31:0]         rd_data_i,
  output logic                wr_en_o,
  output logic [15:0]         wr_addr_o,
  output logic [31:0]         wr_data_o,
  output logic                div_start_o,
  output logic [31:0]         div_num_o,
  output logic [15:0]         div_den_o,
  input  logic                div_done_i,
  input  logic [31:0]         div_quo_i
);
  import bbis_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_STEP  = 12'b000000000010,
    S_EPOS  = 12'b000000000100,
    S_ERDA  = 12'b000000001000,
    S_ERDB  = 12'b000000010000,
    S_EMIX  = 12'b000000100000,
    S_RMAP  = 12'b000001000000,
    S_RWAIT = 12'b000010000000,
    S_RRD   = 12'b000100000000,
    S_RACC  = 12'b001000000000,
    S_RDIV  = 12'b010000000000,
    S_RDW   = 12'b100000000000
  } st_e;

  st_e st_q, st_d;
  pass_req_t rq_q, rq_d;
  logic [16:0] step_q, step_d;
  logic [8:0] j_q, j_d;
  logic [8:0] i_q, i_d;
  logic [7:0] t_q, t_d;
  logic [8:0] p0_q, p0_d, p1_q, p1_d;
  logic [31:0] a_q, a_d;
  logic [8:0] k_q, k_d, last_q, last_d;
  logic [8:0] cnt_q, cnt_d;
  logic [16:0] sum_q [4];
  logic [16:0] sum_d [4];
  logic [1:0] ch_q, ch_d;
  logic [31:0] out_q, out_d;
  logic first_q, first_d;
  logic [24:0] pos;
  logic [8:0] ip;
  logic [8:0] nm1;
  logic [16:0] ofs;
  logic [15:0] mix [4];
  logic [24:0] prod;

  assign nm1 = rq_q.n_src - 9'd1;
  assign pos = {8'd0, step_q} * {16'd0, j_q};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mix[c] = 16'(({8'd0, a_q[8*c +: 8]} * {8'd0, 8'd255 - t_q}
               + {8'd0, rd_data_i[8*c +: 8]} * {8'd0, t_q}));
    end
  end

  always_comb begin
    st_d = st_q; rq_d = rq_q; step_d = step_q; j_d = j_q; i_d = i_q; t_d = t_q;
    p0_d = p0_q; p1_d = p1_q; a_d = a_q; k_d = k_q; last_d = last_q; cnt_d = cnt_q;
    sum_d = sum_q; ch_d = ch_q; out_d = out_q; first_d = first_q;
    done_o = 1'b0; rd_en_o = 1'b0; rd_addr_o = '0; wr_en_o = 1'b0;
    wr_addr_o = '0; wr_data_o = '0; div_start_o = 1'b0; div_num_o = '0; div_den_o = '0;
    ip = '0; ofs = '0; prod = '0;
    case (st_q)
      S_IDLE: begin
        if (req_i.go) begin
          rq_d = req_i; j_d = '0; i_d = '0; cnt_d = '0; first_d = 1'b1;
          for (int c = 0; c < 4; c++) sum_d[c] = '0;
          if (req_i.n_dst > req_i.n_src) begin
            div_start_o = 1'b1;
            div_num_o = {7'd0, req_i.n_src, 16'd0};
            div_den_o = {7'd0, req_i.n_dst};
            st_d = S_STEP;
          end else begin
            st_d = S_RMAP;
          end
        end
      end
      S_STEP: begin
        if (div_done_i) begin
          step_d = div_quo_i[16:0];
          st_d = S_EPOS;
        end
      end
      S_EPOS: begin
        t_d = '0; ip = '0;
        if (pos >= 25'h8000) begin
          prod = 25'(pos - 25'h8000);
          ip = prod[24:16];
          t_d = 8'(({8'd0, prod[15:0]} * 24'd255) >> 16);
        end
        p0_d = (ip < nm1) ? ip : nm1;
        p1_d = ((ip + 9'd1) < nm1) ? ip + 9'd1 : nm1;
        st_d = S_ERDA;
      end
      S_ERDA: begin
        rd_en_o = 1'b1;
        rd_addr_o = 16'(rq_q.sb + 16'(rq_q.ss * {7'd0, p0_q}));
        st_d = S_ERDB;
      end
      S_ERDB: begin
        a_d = rd_data_i;
        rd_en_o = 1'b1;
        rd_addr_o = 16'(rq_q.sb + 16'(rq_q.ss * {7'd0, p1_q}));
        st_d = S_EMIX;
      end
      S_EMIX: begin
        wr_en_o = 1'b1;
        wr_addr_o = 16'(rq_q.db + 16'(rq_q.ds * {7'd0, j_q}));
        for (int c = 0; c < 4; c++) wr_data_o[8*c +: 8] = mix[c][15:8];
        j_d = j_q + 9'd1;
        if (j_d == rq_q.n_dst) begin
          st_d = S_IDLE; done_o = 1'b1;
        end else begin
          st_d = S_EPOS;
        end
      end
      S_RMAP: begin
        if (i_q == rq_q.n_src) begin
          k_d = rq_q.n_dst;
          st_d = S_RWAIT;
        end else if (rq_q.n_src == 9'd1) begin
          k_d = '0;
          st_d = S_RWAIT;
        end else begin
          div_start_o = 1'b1;
          div_num_o = 32'({9'd0, i_q} * {9'd0, rq_q.n_dst});
          div_den_o = {7'd0, nm1};
          st_d = S_RWAIT;
          k_d = 9'h1ff;
        end
      end
      S_RWAIT: begin
        if (k_q != 9'h1ff || div_done_i) begin
          if (k_q == 9'h1ff) begin
            k_d = (div_quo_i >= {23'd0, rq_q.n_dst - 9'd1}) ? rq_q.n_dst - 9'd1
                  : div_quo_i[8:0];
          end
          if (first_q) last_d = k_d;
          first_d = 1'b0;
          if ((first_q ? 1'b0 : (k_d != last_q)) && cnt_q != 9'd0) begin
            ch_d = '0;
            st_d = S_RDIV;
          end else begin
            last_d = k_d;
            st_d = S_RRD;
          end
        end
      end
      S_RDIV: begin
        div_start_o = 1'b1;
        div_num_o = {15'd0, sum_q[ch_q]};
        div_den_o = {7'd0, cnt_q};
        st_d = S_RDW;
      end
      S_RDW: begin
        if (div_done_i) begin
          out_d[8*ch_q +: 8] = div_quo_i[7:0];
          if (ch_q == 2'd3) begin
            wr_en_o = 1'b1;
            wr_addr_o = 16'(rq_q.db + 16'(rq_q.ds * {7'd0, last_q}));
            wr_data_o = {div_quo_i[7:0], out_q[23:0]};
            for (int c = 0; c < 4; c++) sum_d[c] = '0;
            cnt_d = '0;
            last_d = k_q;
            st_d = S_RRD;
          end else begin
            ch_d = ch_q + 2'd1;
            st_d = S_RDIV;
          end
        end
      end
      S_RRD: begin
        if (i_q == rq_q.n_src) begin
          st_d = S_IDLE; done_o = 1'b1;
        end else begin
          rd_en_o = 1'b1;
          ofs = 17'(rq_q.ss * {7'd0, i_q});
          rd_addr_o = 16'(rq_q.sb + ofs[15:0]);
          st_d = S_RACC;
        end
      end
      S_RACC: begin
        for (int c = 0; c < 4; c++) sum_d[c] = sum_q[c] + {9'd0, rd_data_i[8*c +: 8]};
        cnt_d = cnt_q + 9'd1;
        i_d = i_q + 9'd1;
        st_d = S_RMAP;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; step_q <= step_d; j_q <= j_d; i_q <= i_d; t_q <= t_d;
    p0_q <= p0_d; p1_q <= p1_d; a_q <= a_d; k_q <= k_d; last_q <= last_d;
    cnt_q <= cnt_d; sum_q <= sum_d; ch_q <= ch_d; out_q <= out_d; first_q <= first_d;
  end
endmodule

// ===== rtl/bilinear_box_image_scaler.sv =====
// Top level of the bilinear/box image scaler: control, stores and readout.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start_i / busy_o   | func_i, red_in_i, green_in_i, blue_in_i,
//           |                    | alpha_in_i
//  result   | strobe_o           | red_out_o .. alpha_out_o, last_pixel_o,
//           |                    | status_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A load item writes the source store in C_LWR. The item that completes the
// frame then holds busy_o high while both passes run, unless the region does
// not fit: an enlarging pass reads two source pixels, mixes and writes each
// destination pixel; a shrinking pass runs a map division per source pixel
// plus four per output run. A fetch item takes a store read and result register.
// Reset clears all control state; the stores need no clearing.
// The receiver cannot stall; strobe_o is high for exactly one cycle per result.
module bilinear_box_image_scaler (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       func_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  output logic       strobe_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [7:0] alpha_out_o,
  output logic       last_pixel_o,
  output logic [1:0] status_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i
);
  import bbis_pkg::*;

  typedef enum logic [7:0] {
    C_LOAD  = 8'b00000001,
    C_LWR   = 8'b00000010,
    C_HPASS = 8'b00000100,
    C_HWAIT = 8'b00001000,
    C_VPASS = 8'b00010000,
    C_VWAIT = 8'b00100000,
    C_READ  = 8'b01000000,
    C_FOUT  = 8'b10000000
  } ctl_e;

  ctl_e st_q, st_d;
  logic [8:0] img_w_q, img_h_q, rw_q, rh_q, dw_q, dh_q;
  logic [7:0] rx_q, ry_q;
  logic [8:0] fw_q, fw_d, fh_q, fh_d;
  logic [CntW-1:0] ld_cnt_q, ld_cnt_d, em_cnt_q, em_cnt_d;
  logic err_q, err_d, rdy_q, rdy_d;
  logic [8:0] line_q, line_d;
  logic [31:0] pix_q, pix_d;

  // Per-frame effective sizes.
  logic [8:0] iw, ih, rw, rh, dw, dh;
  assign iw = eff_size(img_w_q);
  assign ih = eff_size(img_h_q);
  assign rw = eff_size(rw_q);
  assign rh = eff_size(rh_q);
  assign dw = eff_size(dw_q);
  assign dh = eff_size(dh_q);

  logic [16:0] ld_total, em_total;
  assign ld_total = 17'({8'd0, iw} * {8'd0, ih});
  assign em_total = 17'({8'd0, fw_q} * {8'd0, fh_q});

  // Stores.
  logic [31:0] src_mem [MaxW*MaxH];
  logic [31:0] mid_mem [MaxW*MaxH];
  logic [31:0] src_rd_q, mid_rd_q;

  pass_req_t req;
  logic p_done, p_rd_en, p_wr_en, d_start, d_done;
  logic [15:0] p_rd_addr, p_wr_addr, d_den;
  logic [31:0] p_wr_data, d_num, d_quo, p_rd_data;
  logic vert;

  assign vert = (st_q == C_VPASS) || (st_q == C_VWAIT);
  assign p_rd_data = vert ? mid_rd_q : src_rd_q;

  logic src_we, mid_we, src_re;
  logic [15:0] src_wa, src_ra, mid_wa;
  logic [31:0] src_wd, mid_wd;
  logic res_v_q, res_v_d, res_last_q, res_last_d;
  logic [1:0] res_st_q, res_st_d;
  logic [31:0] res_px_q, res_px_d;

  always_comb begin
    src_we = 1'b0; src_wa = '0; src_wd = '0;
    mid_we = 1'b0; mid_wa = p_wr_addr; mid_wd = p_wr_data;
    src_re = 1'b0; src_ra = p_rd_addr;
    if (st_q == C_LWR) begin
      src_we = 1'b1; src_wa = ld_cnt_q[15:0]; src_wd = pix_q;
    end else if (vert) begin
      src_we = p_wr_en; src_wa = p_wr_addr; src_wd = p_wr_data;
    end else if (st_q == C_HPASS || st_q == C_HWAIT) begin
      mid_we = p_wr_en;
      src_re = p_rd_en;
    end
    if (st_q == C_READ) begin
      src_re = 1'b1; src_ra = em_cnt_q[15:0];
    end
    if (!(st_q == C_HPASS || st_q == C_HWAIT)) mid_we = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (src_re) src_rd_q <= src_mem[src_ra];
    if (mid_we) mid_mem[mid_wa] <= mid_wd;
    if (p_rd_en) mid_rd_q <= mid_mem[p_rd_addr];
  end

  always_comb begin
    req = '0;
    req.go = (st_q == C_HPASS) || (st_q == C_VPASS);
    if (st_q == C_HPASS) begin
      req.sb = 16'((({8'd0, ry_q} + {7'd0, line_q}) * {8'd0, iw}) + {9'd0, rx_q});
      req.ss = 16'd1; req.n_src = rw;
      req.db = 16'({7'd0, line_q} * {7'd0, dw}); req.ds = 16'd1; req.n_dst = dw;
    end else begin
      req.vert = 1'b1;
      req.sb = {7'd0, line_q}; req.ss = {7'd0, dw}; req.n_src = rh;
      req.db = {7'd0, line_q}; req.ds = {7'd0, dw}; req.n_dst = dh;
    end
  end

  bbis_div u_div (
    .clk_i, .rst_ni, .start_i(d_start), .num_i(d_num), .den_i(d_den),
    .done_o(d_done), .quo_o(d_quo)
  );

  bbis_pass u_pass (
    .clk_i, .rst_ni, .req_i(req), .done_o(p_done),
    .rd_en_o(p_rd_en), .rd_addr_o(p_rd_addr), .rd_data_i(p_rd_data),
    .wr_en_o(p_wr_en), .wr_addr_o(p_wr_addr), .wr_data_o(p_wr_data),
    .div_start_o(d_start), .div_num_o(d_num), .div_den_o(d_den),
    .div_done_i(d_done), .div_quo_i(d_quo)
  );

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != C_LOAD);

  always_comb begin
    st_d = st_q; ld_cnt_d = ld_cnt_q; em_cnt_d = em_cnt_q; err_d = err_q;
    rdy_d = rdy_q; line_d = line_q; pix_d = pix_q; fw_d = fw_q; fh_d = fh_q;
    res_v_d = 1'b0; res_last_d = 1'b0; res_st_d = StOk; res_px_d = '0;
    case (st_q)
      C_LOAD: begin
        if (accept) begin
          if (!func_i) begin
            if (!rdy_q && !err_q) begin
              pix_d = {alpha_in_i, blue_in_i, green_in_i, red_in_i};
              st_d = C_LWR;
            end
          end else if (err_q) begin
            res_v_d = 1'b1; res_last_d = 1'b1; res_st_d = StRegion;
            err_d = 1'b0; ld_cnt_d = '0; em_cnt_d = '0;
          end else if (!rdy_q) begin
            res_v_d = 1'b1; res_st_d = StNotReady;
          end else begin
            st_d = C_READ;
          end
        end
      end
      C_LWR: begin
        ld_cnt_d = ld_cnt_q + 17'd1;
        st_d = C_LOAD;
        if (ld_cnt_d >= ld_total) begin
          ld_cnt_d = '0;
          if ((10'(rx_q) + 10'(rw)) > 10'(iw) || (10'(ry_q) + 10'(rh)) > 10'(ih)) begin
            err_d = 1'b1;
          end else begin
            line_d = '0;
            st_d = C_HPASS;
          end
        end
      end
      C_HPASS: st_d = C_HWAIT;
      C_HWAIT: begin
        if (p_done) begin
          line_d = line_q + 9'd1;
          if (line_d == rh) begin
            line_d = '0; st_d = C_VPASS;
          end else begin
            st_d = C_HPASS;
          end
        end
      end
      C_VPASS: st_d = C_VWAIT;
      C_VWAIT: begin
        if (p_done) begin
          line_d = line_q + 9'd1;
          if (line_d == dw) begin
            fw_d = dw; fh_d = dh; em_cnt_d = '0; rdy_d = 1'b1;
            st_d = C_LOAD;
          end else begin
            st_d = C_VPASS;
          end
        end
      end
      C_READ: st_d = C_FOUT;
      C_FOUT: begin
        res_v_d = 1'b1; res_px_d = src_rd_q; res_st_d = StOk;
        em_cnt_d = em_cnt_q + 17'd1;
        if (em_cnt_d >= em_total) begin
          res_last_d = 1'b1; em_cnt_d = '0; ld_cnt_d = '0; rdy_d = 1'b0;
        end
        st_d = C_LOAD;
      end
      default: st_d = C_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_LOAD; ld_cnt_q <= '0; em_cnt_q <= '0; err_q <= 1'b0; rdy_q <= 1'b0;
      line_q <= '0; fw_q <= 9'd1; fh_q <= 9'd1; res_v_q <= 1'b0;
      img_w_q <= 9'd256; img_h_q <= 9'd256; rx_q <= '0; ry_q <= '0;
      rw_q <= 9'd256; rh_q <= 9'd256; dw_q <= 9'd256; dh_q <= 9'd256;
    end else begin
      st_q <= st_d; ld_cnt_q <= ld_cnt_d; em_cnt_q <= em_cnt_d; err_q <= err_d;
      rdy_q <= rdy_d; line_q <= line_d; fw_q <= fw_d; fh_q <= fh_d;
      res_v_q <= res_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegImgW: img_w_q <= cfg_data_i;
          RegImgH: img_h_q <= cfg_data_i;
          RegRx:   rx_q <= cfg_data_i[7:0];
          RegRy:   ry_q <= cfg_data_i[7:0];
          RegRw:   rw_q <= cfg_data_i;
          RegRh:   rh_q <= cfg_data_i;
          RegDw:   dw_q <= cfg_data_i;
          RegDh:   dh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d; res_last_q <= res_last_d; res_st_q <= res_st_d; res_px_q <= res_px_d;
  end

  assign strobe_o = res_v_q;
  assign red_out_o = res_px_q[7:0];
  assign green_out_o = res_px_q[15:8];
  assign blue_out_o = res_px_q[23:16];
  assign alpha_out_o = res_px_q[31:24];
  assign last_pixel_o = res_last_q;
  assign status_o = res_st_q;
endmodule

// ===== rtl/bbis_checker.sv =====
// Port-level checker for the image scaler, bound to the top level.
module bbis_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       func_i,
  input logic       strobe_o,
  input logic       last_pixel_o,
  input logic [1:0] status_o
);
  import bbis_pkg::*;

  a_no_strobe_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !func_i) |=> !strobe_o) else $error("result after load");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (status_o == StOk || status_o == StRegion || status_o == StNotReady))
    else $error("bad status");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == StRegion) |-> last_pixel_o) else $error("error not last");

  a_notready_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == StNotReady) |-> !last_pixel_o) else $error("not ready last");
endmodule

bind bilinear_box_image_scaler bbis_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .strobe_o, .last_pixel_o, .status_o
);
